// ===== hdl/stfe_pkg.sv =====
package stfe_pkg;

	localparam logic [7:0] SYNC_STATUS  = 8'hA5;
	localparam logic [7:0] SYNC_HISTORY = 8'hA6;
	localparam logic [7:0] SYNC_HEADER  = 8'hA7;
	localparam logic [7:0] MAX_PAYLOAD  = 8'd32;

	localparam logic FUNC_STATUS = 1'b0;
	localparam logic FUNC_TEXT   = 1'b1;

	localparam int unsigned CMD_BYTES = 4;

	typedef struct packed {
		logic       func;
		logic [2:0] input_mode;
		logic [1:0] socd_mode;
		logic       auth_flag;
		logic       frame_kind;
		logic [7:0] frame_len;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       packet_end;
	} link_t;

	// one classified item: up to four bytes, flag marks the last as packet end
	typedef struct packed {
		logic [CMD_BYTES-1:0][7:0] bytes;
		logic [2:0]                cnt;
		logic                      pkt_end;
	} cmd_t;

endpackage

// ===== hdl/status_and_text_frame_encoder.sv =====
// Byte framer for a serial link. Each request on the item channel is either a
// status request (four bytes out: 0xA5, packed mode byte, auth byte, XOR
// check, the last flagged packet_end) or one payload byte of a text frame.
// The first byte of a frame also sends the header byte (0xA6/0xA7) and the
// length capped at 32; payload past the cap is swallowed, and the XOR
// checksum follows the last kept byte with packet_end set. Zero length sends
// nothing and closes any open frame. The front end classifies a request in
// the cycle it is taken and can take one per cycle while the command queue
// has room; the back end sends one byte per cycle while the link is ready,
// so the sustained rate is set by the output port and by the bytes each
// request makes: 4 for status, 3 for the first byte of a frame or 4 when
// that frame is one byte long, 1 or 2 otherwise, none for dropped bytes.
// Output is registered, so the link side may stall freely.
module status_and_text_frame_encoder #(
	parameter int unsigned QUEUE_DEPTH = 2 // command queue entries, 2 or more
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  stfe_pkg::item_t item,
	output logic            link_valid,
	input  logic            link_ready,
	output stfe_pkg::link_t link
);

	logic           q_full;
	logic           q_push;
	logic           q_pop;
	logic           q_nonempty;
	stfe_pkg::cmd_t wr_cmd;
	stfe_pkg::cmd_t rd_cmd;

	// front: takes requests, tracks frame position and running checksum
	stfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (wr_cmd)
	);

	// decouples classification from the byte-serial output
	stfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_cmd   (wr_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.rd_cmd   (rd_cmd)
	);

	// back: unrolls each command into bytes on the link
	stfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_cmd      (rd_cmd),
		.q_pop      (q_pop),
		.link_valid (link_valid),
		.link_ready (link_ready),
		.link       (link)
	);

endmodule

// ===== hdl/stfe_front.sv =====
module stfe_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  stfe_pkg::item_t item,
	input  logic            q_full,
	output logic            q_push,
	output stfe_pkg::cmd_t  q_cmd
);

	logic [7:0] pos_q;
	logic [7:0] xor_q;
	logic [7:0] pos_n;
	logic [7:0] xor_n;
	logic [7:0] cap;
	logic [7:0] packed_st;
	logic [7:0] x;
	logic [8:0] pos_inc;
	logic [2:0] k;
	logic       accept;

	assign item_ready = !q_full;
	assign accept     = item_valid && item_ready;
	assign cap        = (item.frame_len > stfe_pkg::MAX_PAYLOAD) ? stfe_pkg::MAX_PAYLOAD
	                                                             : item.frame_len;
	assign packed_st  = {3'b000, item.socd_mode, item.input_mode};
	assign pos_inc    = {1'b0, pos_q} + 9'd1;

	always_comb begin
		q_cmd = '0;
		pos_n = pos_q;
		xor_n = xor_q;
		x     = xor_q;
		k     = 3'd0;
		if (item.func == stfe_pkg::FUNC_STATUS) begin
			q_cmd.bytes[0] = stfe_pkg::SYNC_STATUS;
			q_cmd.bytes[1] = packed_st;
			q_cmd.bytes[2] = {7'd0, item.auth_flag};
			q_cmd.bytes[3] = packed_st ^ {7'd0, item.auth_flag};
			q_cmd.cnt      = 3'd4;
			q_cmd.pkt_end  = 1'b1;
		end else if (item.frame_len == 8'd0) begin
			pos_n = 8'd0;
			xor_n = 8'd0;
		end else begin
			if (pos_q == 8'd0) begin
				q_cmd.bytes[0] = item.frame_kind ? stfe_pkg::SYNC_HEADER
				                                 : stfe_pkg::SYNC_HISTORY;
				q_cmd.bytes[1] = cap;
				x              = cap;
				k              = 3'd2;
			end
			if (pos_q < cap) begin
				x                   = x ^ item.data_byte;
				q_cmd.bytes[k[1:0]] = item.data_byte;
				k                   = k + 3'd1;
				if (pos_inc == {1'b0, cap}) begin
					q_cmd.bytes[k[1:0]] = x;
					k                   = k + 3'd1;
					q_cmd.pkt_end       = 1'b1;
				end
			end
			q_cmd.cnt = k;
			if (pos_inc >= {1'b0, item.frame_len}) begin
				pos_n = 8'd0;
				xor_n = 8'd0;
			end else begin
				pos_n = pos_inc[7:0];
				xor_n = x;
			end
		end
	end

	// empty commands (zero length, dropped bytes) never enter the queue
	assign q_push = accept && (q_cmd.cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 8'd0;
			xor_q <= 8'd0;
		end else if (accept && item.func == stfe_pkg::FUNC_TEXT) begin
			pos_q <= pos_n;
			xor_q <= xor_n;
		end
	end

endmodule

// ===== hdl/stfe_queue.sv =====
module stfe_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  stfe_pkg::cmd_t wr_cmd,
	output logic           full,
	input  logic           pop,
	output logic           nonempty,
	output stfe_pkg::cmd_t rd_cmd
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	stfe_pkg::cmd_t mem [DEPTH];
	logic [PW-1:0]  wptr_q;
	logic [PW-1:0]  rptr_q;
	logic [CW-1:0]  count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign rd_cmd   = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == LAST) ? '0 : wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == LAST) ? '0 : rptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== hdl/stfe_back.sv =====
module stfe_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_nonempty,
	input  stfe_pkg::cmd_t  q_cmd,
	output logic            q_pop,
	output logic            link_valid,
	input  logic            link_ready,
	output stfe_pkg::link_t link
);

	stfe_pkg::cmd_t  cur_q;
	logic [1:0]      idx_q;
	logic            busy_q;
	stfe_pkg::link_t out_q;
	logic            out_valid_q;
	logic            adv;
	logic            last;
	logic            load;

	assign adv   = !out_valid_q || link_ready;
	assign last  = ({1'b0, idx_q} + 3'd1) == cur_q.cnt;
	// refill on the cycle the last byte leaves, so commands run back to back
	assign load  = q_nonempty && (!busy_q || (adv && last));
	assign q_pop = load;

	assign link_valid = out_valid_q;
	assign link       = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= q_cmd;
		end
		if (adv && busy_q) begin
			out_q.out_byte   <= cur_q.bytes[idx_q];
			out_q.packet_end <= last && cur_q.pkt_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= busy_q;
			end
			if (load) begin
				idx_q  <= 2'd0;
				busy_q <= 1'b1;
			end else if (adv && busy_q) begin
				if (last) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

endmodule

// ===== bench/status_and_text_frame_encoder_test.sv =====
module status_and_text_frame_encoder_test;

	localparam int ITEM_W = $bits(stfe_pkg::item_t);

	// Running copy of the framer: open-frame position and checksum, plus the
	// bytes still owed on the link side, oldest first.
	class link_byte_tracker;
		int unsigned      frame_pos;
		logic [7:0]       frame_xor;
		stfe_pkg::link_t  due_bytes[$];
		int               failures;
		int               n_status;
		int               n_text;
		int               n_checksums;
		int               n_checked;

		function new();
			frame_pos = 0;
			frame_xor = '0;
		endfunction

		function void push(logic [7:0] b, logic last);
			due_bytes.push_back('{out_byte: b, packet_end: last});
		endfunction

		function int pending();
			return due_bytes.size();
		endfunction

		function void note_request(stfe_pkg::item_t r);
			int unsigned len;
			int unsigned cap;
			logic [7:0]  status_byte;
			logic [7:0]  auth_byte;
			if (r.func == stfe_pkg::FUNC_STATUS) begin
				// status goes out whole and leaves any open frame alone
				status_byte = {3'b000, r.socd_mode, r.input_mode};
				auth_byte = {7'b0, r.auth_flag};
				push(stfe_pkg::SYNC_STATUS, 1'b0);
				push(status_byte, 1'b0);
				push(auth_byte, 1'b0);
				push(status_byte ^ auth_byte, 1'b1);
				n_status++;
				return;
			end
			n_text++;
			len = r.frame_len;
			if (len == 0) begin
				// zero length: silent, and shuts whatever frame was open
				frame_pos = 0;
				frame_xor = '0;
				return;
			end
			cap = (len > stfe_pkg::MAX_PAYLOAD) ? stfe_pkg::MAX_PAYLOAD : len;
			if (frame_pos == 0) begin
				push(r.frame_kind ? stfe_pkg::SYNC_HEADER : stfe_pkg::SYNC_HISTORY, 1'b0);
				push(8'(cap), 1'b0);
				frame_xor = 8'(cap);
			end
			if (frame_pos < cap) begin
				frame_xor ^= r.data_byte;
				push(r.data_byte, 1'b0);
				if (frame_pos + 1 == cap) begin
					push(frame_xor, 1'b1);
					n_checksums++;
				end
			end
			// each request's own length decides when the frame closes
			frame_pos++;
			if (frame_pos >= len) begin
				frame_pos = 0;
				frame_xor = '0;
			end
		endfunction

		function void check_link_byte(stfe_pkg::link_t got);
			stfe_pkg::link_t want;
			n_checked++;
			if (due_bytes.size() == 0) begin
				$error("unexpected link byte %02h (packet_end %0b)", got.out_byte,
					got.packet_end);
				failures++;
				return;
			end
			want = due_bytes.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
				failures++;
			end
			if (got.packet_end !== want.packet_end) begin
				$error("packet_end: expected %0b, got %0b", want.packet_end, got.packet_end);
				failures++;
			end
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            item_valid = 1'b0;
	logic            item_ready;
	stfe_pkg::item_t item_req = '0;
	logic            link_valid;
	logic            link_ready = 1'b0;
	stfe_pkg::link_t link_out;

	link_byte_tracker tracker = new();

	// idle odds in percent per cycle for each side, changed per phase
	int unsigned send_idle_pct = 29;
	int unsigned recv_idle_pct = 56;
	// raised by the stimulus, taken up and cleared by the link side
	bit          link_hold_request = 1'b0;
	int unsigned n_holds = 0;
	int unsigned items_sent = 0;

	status_and_text_frame_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item_req),
		.link_valid (link_valid),
		.link_ready (link_ready),
		.link       (link_out)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Fields a request does not use are filled with noise; the block must
	// ignore them.
	function automatic stfe_pkg::item_t status_request(logic [2:0] mode, logic [1:0] socd,
		logic auth);
		stfe_pkg::item_t r;
		r = stfe_pkg::item_t'(ITEM_W'($urandom));
		r.func = stfe_pkg::FUNC_STATUS;
		r.input_mode = mode;
		r.socd_mode = socd;
		r.auth_flag = auth;
		return r;
	endfunction

	function automatic stfe_pkg::item_t text_request(logic kind, logic [7:0] len,
		logic [7:0] data);
		stfe_pkg::item_t r;
		r = stfe_pkg::item_t'(ITEM_W'($urandom));
		r.func = stfe_pkg::FUNC_TEXT;
		r.frame_kind = kind;
		r.frame_len = len;
		r.data_byte = data;
		return r;
	endfunction

	function automatic stfe_pkg::item_t random_status();
		return status_request(3'($urandom), 2'($urandom), 1'($urandom));
	endfunction

	// Called at a rising edge. Valid is only dropped on an idle cycle, so
	// back-to-back requests keep it high without a glitch in one step.
	task automatic send_request(stfe_pkg::item_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item_req <= r;
		do
			@(posedge clk);
		while (!item_ready);
		tracker.note_request(r);
		items_sent++;
	endtask

	// cnt text requests all declaring len, each with a random kind, which the
	// block must only use at a frame's start, and status may be slipped in between
	task automatic send_text_run(int unsigned len, int unsigned cnt, int unsigned status_pct);
		for (int unsigned i = 0; i < cnt; i++) begin
			if (i != 0 && $urandom_range(99) < status_pct)
				send_request(random_status());
			send_request(text_request(1'($urandom), 8'(len), 8'($urandom)));
		end
	endtask

	task automatic random_phase(int unsigned n);
		int unsigned start;
		int unsigned pick;
		int unsigned len;
		int unsigned cnt;
		start = items_sent;
		while (items_sent - start < n) begin
			pick = $urandom_range(99);
			if (pick < 25) begin
				send_request(random_status());
			end else if (pick < 80) begin
				// well-formed frame, mostly short, some filling or passing the cap
				pick = $urandom_range(99);
				if (pick < 70)
					len = $urandom_range(1, 8);
				else if (pick < 88)
					len = $urandom_range(9, 32);
				else
					len = $urandom_range(33, 48);
				send_text_run(len, len, 8);
			end else if (pick < 88) begin
				// truncated frame, shut by a zero-length request
				len = $urandom_range(2, 255);
				cnt = $urandom_range(1, (len > 7) ? 6 : len - 1);
				send_text_run(len, cnt, 0);
				send_request(text_request(1'($urandom), 8'd0, 8'($urandom)));
			end else if (pick < 95) begin
				// declared length changes part way through
				len = $urandom_range(2, 12);
				send_text_run(len, $urandom_range(1, len - 1), 0);
				send_text_run($urandom_range(1, 40), $urandom_range(1, 6), 0);
				send_request(text_request(1'($urandom), 8'd0, 8'($urandom)));
			end else begin
				send_request(text_request(1'($urandom), 8'd0, 8'($urandom)));
			end
		end
	endtask

	// Link side: random back-pressure, or a long hold when asked for one.
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			if (hold_left == 0 && link_hold_request) begin
				hold_left = 300;
				link_hold_request = 1'b0;
				n_holds++;
			end
			if (hold_left != 0) begin
				link_ready <= 1'b0;
				hold_left--;
			end else begin
				link_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
			@(posedge clk);
			if (link_valid && link_ready)
				tracker.check_link_byte(link_out);
		end
	end

	initial begin
		#4000000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int unsigned guard;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: status extremes, unused fields full of noise
		send_request(status_request(3'd0, 2'd0, 1'b0));
		send_request(status_request(3'd7, 2'd3, 1'b1));
		// zero length with no frame open
		send_request(text_request(1'b1, 8'd0, 8'hFF));
		// one-byte history frame
		send_request(text_request(1'b0, 8'd1, 8'hFF));
		// two-byte header frame, kind flips on the second byte
		send_request(text_request(1'b1, 8'd2, 8'h00));
		send_request(text_request(1'b0, 8'd2, 8'h5A));
		// status request landing inside an open frame
		send_request(text_request(1'b0, 8'd3, 8'h81));
		send_request(status_request(3'd5, 2'd2, 1'b1));
		send_request(text_request(1'b1, 8'd3, 8'h7E));
		send_request(text_request(1'b0, 8'd3, 8'hC3));
		// zero length shutting an open frame
		send_request(text_request(1'b1, 8'd4, 8'h11));
		send_request(text_request(1'b1, 8'd0, 8'h22));
		// length cut below the count taken: byte dropped, no checksum
		send_request(text_request(1'b0, 8'd5, 8'h33));
		send_request(text_request(1'b0, 8'd5, 8'h44));
		send_request(text_request(1'b0, 8'd2, 8'h55));
		// longest declared length, abandoned early
		send_request(text_request(1'b1, 8'd255, 8'hAA));
		send_request(text_request(1'b1, 8'd255, 8'h01));
		send_request(text_request(1'b0, 8'd0, 8'h00));
		// one frame past the cap: 32 kept, the rest swallowed
		send_text_run(34, 34, 0);

		random_phase(95);

		send_idle_pct = 56;
		recv_idle_pct = 29;
		random_phase(95);

		// no idling; the link is held off early so the block backs up
		send_idle_pct = 0;
		recv_idle_pct = 0;
		link_hold_request = 1'b1;
		random_phase(100);

		item_valid <= 1'b0;

		guard = 0;
		while (tracker.pending() != 0 && guard < 50000) begin
			@(posedge clk);
			guard++;
		end
		// room for a stray byte to show up after the last one owed
		repeat (20) @(posedge clk);
		if (tracker.pending() != 0) begin
			$error("%0d link bytes never arrived", tracker.pending());
			tracker.failures++;
		end

		$display("Covered %0d status and %0d text requests, %0d frame checksums,",
			tracker.n_status, tracker.n_text, tracker.n_checksums);
		$display("%0d link bytes compared over three idling phases and %0d long link hold.",
			tracker.n_checked, n_holds);
		if (tracker.failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/stfe_pkg.sv
hdl/stfe_front.sv
hdl/stfe_queue.sv
hdl/stfe_back.sv
hdl/status_and_text_frame_encoder.sv
bench/status_and_text_frame_encoder_test.sv
